>>> src/bresenham_line_rasterizer_defines.svh
// Assertion macros shared by the checker of the line rasterizer.
// Each macro expects clk and rst to be visible where it is used.
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brl: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brl: next-cycle check failed");

`endif

>>> src/brl_pkg.sv
`default_nettype none

package brl_pkg;

  localparam int COORD_W = 16;
  localparam int SPAN_W  = 16;
  localparam int ERR_W   = 18;
  localparam int COLOR_W = 8;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  // One classified command as it travels from the front to the engine.
  typedef struct packed {
    func_t                      func;
    logic signed [COORD_W-1:0]  cur_x;
    logic signed [COORD_W-1:0]  cur_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic        [SPAN_W-1:0]   span_x;
    logic        [SPAN_W-1:0]   span_y;
    logic                       step_x_neg;
    logic                       step_y_neg;
    logic signed [ERR_W-1:0]    error_term;
    logic        [COLOR_W-1:0]  color;
  } cmd_t;

  // One pixel beat as it leaves the engine.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [COLOR_W-1:0] color;
    logic                      visible;
    logic                      last;
  } pix_t;

endpackage

`default_nettype wire

>>> src/brl_front.sv
`default_nettype none

// Accepts input beats and turns a start beat into a ready-to-run line setup.
module brl_front (
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic signed [brl_pkg::COORD_W-1:0]   x_start,
  input  logic signed [brl_pkg::COORD_W-1:0]   y_start,
  input  logic signed [brl_pkg::COORD_W-1:0]   x_end,
  input  logic signed [brl_pkg::COORD_W-1:0]   y_end,
  input  logic        [brl_pkg::COLOR_W-1:0]   color,
  input  logic                                 q_full,
  output logic                                 push,
  output brl_pkg::cmd_t                        cmd
);

  logic [brl_pkg::COORD_W:0]   dx, dy;
  logic [brl_pkg::COORD_W:0]   ax, ay;
  logic                        lt_x, lt_y;
  logic [brl_pkg::SPAN_W-1:0]  sx, sy;
  logic                        axis;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    dx   = {x_end[brl_pkg::COORD_W-1], x_end} - {x_start[brl_pkg::COORD_W-1], x_start};
    dy   = {y_end[brl_pkg::COORD_W-1], y_end} - {y_start[brl_pkg::COORD_W-1], y_start};
    lt_x = !dx[brl_pkg::COORD_W] && (dx != '0);
    lt_y = !dy[brl_pkg::COORD_W] && (dy != '0);
    ax   = dx[brl_pkg::COORD_W] ? ('0 - dx) : dx;
    ay   = dy[brl_pkg::COORD_W] ? ('0 - dy) : dy;
    sx   = ax[brl_pkg::SPAN_W-1:0];
    sy   = ay[brl_pkg::SPAN_W-1:0];
    axis = (sx == '0) || (sy == '0);

    cmd.func   = (func == brl_pkg::FUNC_START) ? brl_pkg::FUNC_START : brl_pkg::FUNC_STEP;
    cmd.span_x = sx;
    cmd.span_y = sy;
    cmd.color  = color;
    if (sx > sy) begin
      cmd.error_term = $signed({{(brl_pkg::ERR_W-brl_pkg::SPAN_W+1){1'b0}},
                                sx[brl_pkg::SPAN_W-1:1]});
    end else begin
      cmd.error_term = -$signed({{(brl_pkg::ERR_W-brl_pkg::SPAN_W+1){1'b0}},
                                 sy[brl_pkg::SPAN_W-1:1]});
    end
    if (axis) begin
      // Axis-aligned lines always walk upward from the lower coordinate.
      cmd.cur_x      = lt_x ? x_start : x_end;
      cmd.end_x      = lt_x ? x_end : x_start;
      cmd.cur_y      = lt_y ? y_start : y_end;
      cmd.end_y      = lt_y ? y_end : y_start;
      cmd.step_x_neg = 1'b0;
      cmd.step_y_neg = 1'b0;
    end else begin
      cmd.cur_x      = x_start;
      cmd.end_x      = x_end;
      cmd.cur_y      = y_start;
      cmd.end_y      = y_end;
      cmd.step_x_neg = !lt_x;
      cmd.step_y_neg = !lt_y;
    end
  end

endmodule

`default_nettype wire

>>> src/brl_fifo.sv
`default_nettype none

// Short first-in first-out queue of commands between front and engine.
module brl_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brl_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output brl_pkg::cmd_t q_data
);

  localparam int LastIdx = brl_pkg::QUEUE_DEPTH - 1;

  brl_pkg::cmd_t                    slots [brl_pkg::QUEUE_DEPTH];
  logic [brl_pkg::QPTR_W-1:0]       wptr, rptr;
  logic [brl_pkg::QCNT_W-1:0]       count;
  logic                             do_push, do_pop;

  assign full    = (count == brl_pkg::QCNT_W'(brl_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == brl_pkg::QPTR_W'(LastIdx)) ? '0 : wptr + brl_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == brl_pkg::QPTR_W'(LastIdx)) ? '0 : rptr + brl_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + brl_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - brl_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/brl_engine.sv
`default_nettype none

// Walks the current line one pixel per step command into an output register.
module brl_engine #(
  parameter int SCREEN_WIDTH  = brl_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = brl_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  brl_pkg::cmd_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output brl_pkg::pix_t pix
);

  logic                                busy;
  logic signed [brl_pkg::COORD_W-1:0]  cur_x, cur_y, end_x, end_y;
  logic        [brl_pkg::SPAN_W-1:0]   span_x, span_y;
  logic                                step_x_neg, step_y_neg;
  logic signed [brl_pkg::ERR_W-1:0]    error_term, error_term_next;
  logic        [brl_pkg::COLOR_W-1:0]  line_color;

  logic                                is_start, out_free, emit;
  logic                                vis, fin, move_x, move_y;
  logic signed [brl_pkg::ERR_W-1:0]    sx_e, sy_e;

  always_comb begin
    is_start = (q_data.func == brl_pkg::FUNC_START);
    out_free = !out_valid || out_ready;
    pop      = q_valid && (is_start || !busy || out_free);
    emit     = q_valid && !is_start && busy && out_free;

    vis = !cur_x[brl_pkg::COORD_W-1] && !cur_y[brl_pkg::COORD_W-1]
          && ($unsigned(cur_x) < brl_pkg::COORD_W'(SCREEN_WIDTH))
          && ($unsigned(cur_y) < brl_pkg::COORD_W'(SCREEN_HEIGHT));
    fin = (cur_x == end_x) && (cur_y == end_y);

    sx_e   = $signed({{(brl_pkg::ERR_W-brl_pkg::SPAN_W){1'b0}}, span_x});
    sy_e   = $signed({{(brl_pkg::ERR_W-brl_pkg::SPAN_W){1'b0}}, span_y});
    move_x = error_term > -sx_e;
    move_y = error_term < sy_e;
    error_term_next = error_term - (move_x ? sy_e : '0) + (move_y ? sx_e : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && is_start) begin
        busy <= 1'b1;
      end else if (emit && fin) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_start) begin
      cur_x      <= q_data.cur_x;
      cur_y      <= q_data.cur_y;
      end_x      <= q_data.end_x;
      end_y      <= q_data.end_y;
      span_x     <= q_data.span_x;
      span_y     <= q_data.span_y;
      step_x_neg <= q_data.step_x_neg;
      step_y_neg <= q_data.step_y_neg;
      error_term <= q_data.error_term;
      line_color <= q_data.color;
    end else if (emit && !fin) begin
      error_term <= error_term_next;
      if (move_x) begin
        cur_x <= step_x_neg ? cur_x - brl_pkg::COORD_W'(1) : cur_x + brl_pkg::COORD_W'(1);
      end
      if (move_y) begin
        cur_y <= step_y_neg ? cur_y - brl_pkg::COORD_W'(1) : cur_y + brl_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix.x       <= cur_x;
      pix.y       <= cur_y;
      pix.color   <= line_color;
      pix.visible <= vis;
      pix.last    <= fin;
    end
  end

endmodule

`default_nettype wire

>>> src/bresenham_line_rasterizer.sv
// Channel  Direction  Handshake             Beat contents
// input    in         in_valid / in_ready   func, x_start, y_start, x_end, y_end, color
// output   out        out_valid / out_ready pixel_x, pixel_y, pixel_color, visible, last
//
// One input beat is taken per cycle unless the queue is full; a step beat goes
// through a queue slot into the output register, and one pixel leaves per cycle
// while out_ready is high, paced by the engine's error update and position step.
// Reset (rst, synchronous, active high) empties the queue and leaves the engine idle.
// A stalled output holds the pixel register; the queue absorbs up to two beats
// before in_ready drops.
`default_nettype none

module bresenham_line_rasterizer #(
  parameter int SCREEN_WIDTH  = brl_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = brl_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                func,
  input  logic signed [brl_pkg::COORD_W-1:0]  x_start,
  input  logic signed [brl_pkg::COORD_W-1:0]  y_start,
  input  logic signed [brl_pkg::COORD_W-1:0]  x_end,
  input  logic signed [brl_pkg::COORD_W-1:0]  y_end,
  input  logic        [brl_pkg::COLOR_W-1:0]  color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [brl_pkg::COORD_W-1:0]  pixel_x,
  output logic signed [brl_pkg::COORD_W-1:0]  pixel_y,
  output logic        [brl_pkg::COLOR_W-1:0]  pixel_color,
  output logic                                visible,
  output logic                                last
);

  // Commands classified by the front wait here until the engine takes them.
  brl_pkg::cmd_t front_cmd;
  brl_pkg::cmd_t q_data;
  logic          push, q_full, q_valid, pop;
  brl_pkg::pix_t pix;

  // The front computes spans, directions and the starting error term of a
  // start beat in the same cycle that it is accepted.
  brl_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .color    (color),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  brl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // The engine holds the line state. A start command always retires at once,
  // a step while idle is dropped, and a step while busy waits for a free
  // output register.
  brl_engine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix       (pix)
  );

  assign pixel_x     = pix.x;
  assign pixel_y     = pix.y;
  assign pixel_color = pix.color;
  assign visible     = pix.visible;
  assign last        = pix.last;

endmodule

`default_nettype wire

>>> src/brl_checker.sv
`default_nettype none
`include "bresenham_line_rasterizer_defines.svh"

module brl_checker #(
  parameter int SCREEN_WIDTH  = brl_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = brl_pkg::DEF_SCREEN_HEIGHT
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [brl_pkg::COORD_W-1:0]  pixel_x,
  input logic signed [brl_pkg::COORD_W-1:0]  pixel_y,
  input logic        [brl_pkg::COLOR_W-1:0]  pixel_color,
  input logic                                visible,
  input logic                                last
);

  logic x_in, y_in;
  logic [2*brl_pkg::COORD_W+brl_pkg::COLOR_W+1:0] pix_bus;

  assign x_in = !pixel_x[brl_pkg::COORD_W-1]
                && ($unsigned(pixel_x) < brl_pkg::COORD_W'(SCREEN_WIDTH));
  assign y_in = !pixel_y[brl_pkg::COORD_W-1]
                && ($unsigned(pixel_y) < brl_pkg::COORD_W'(SCREEN_HEIGHT));
  assign pix_bus = {pixel_x, pixel_y, pixel_color, visible, last};

  // A stalled pixel stays offered and unchanged.
  `BRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pix_bus))
  // The visible flag agrees with the screen bounds in both directions.
  `BRL_ASSERT_NOW(a_vis_x, out_valid && visible, x_in)
  `BRL_ASSERT_NOW(a_vis_y, out_valid && visible, y_in)
  `BRL_ASSERT_NOW(a_hidden, out_valid && !visible, !x_in || !y_in)

endmodule

bind bresenham_line_rasterizer brl_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_brl_checker (.*);

`default_nettype wire

>>> dv/bresenham_line_rasterizer_test.sv
`default_nettype none

module bresenham_line_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_W = brl_pkg::DEF_SCREEN_WIDTH;
  localparam int SCREEN_H = brl_pkg::DEF_SCREEN_HEIGHT;

  // Total number of beats that do real work (starts and steps on a live line).
  localparam int BEAT_TARGET = 1700;
  // Length of the one long receiver hold-off that forces the input to stall.
  localparam int HOLD_OFF_CYCLES = 300;
  // Cycles without any accepted beat on either side before the run is abandoned.
  localparam int QUIET_LIMIT = 5000;
  // Cycles to keep watching the output after the last expected pixel arrived.
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst;

  logic                               in_valid;
  logic                               in_ready;
  logic                               func;
  logic signed [brl_pkg::COORD_W-1:0] x_start;
  logic signed [brl_pkg::COORD_W-1:0] y_start;
  logic signed [brl_pkg::COORD_W-1:0] x_end;
  logic signed [brl_pkg::COORD_W-1:0] y_end;
  logic        [brl_pkg::COLOR_W-1:0] color;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [brl_pkg::COORD_W-1:0] pixel_x;
  logic signed [brl_pkg::COORD_W-1:0] pixel_y;
  logic        [brl_pkg::COLOR_W-1:0] pixel_color;
  logic                               visible;
  logic                               last;

  bresenham_line_rasterizer #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .color      (color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .visible    (visible),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the line engine. Coordinates and spans are kept as 32-bit
  // integers so that spans of up to 65535 never wrap, just as the engine's
  // widened arithmetic is meant to behave.
  int           pen_x, pen_y;
  int           goal_x, goal_y;
  int           run_x, run_y;
  int           slope_err;
  bit           x_back, y_back;
  logic [7:0]   pen_color;
  bit           drawing;

  // Pixels predicted but not yet seen on the output, oldest first.
  brl_pkg::pix_t pending_pixels[$];

  int  beat_count;
  int  mismatch_count;
  int  quiet_cycles;
  // When set, both sides stop idling so back-to-back beats are exercised.
  bit  steady;
  // Raised by a test to ask the receiver for one long hold-off.
  bit  hold_off_pending;

  // Applies one accepted beat to the shadow engine. Returns 1 when the beat
  // produces a pixel, which is then handed back through px.
  function automatic bit rasterize_beat(input brl_pkg::func_t f,
                                        input logic signed [15:0] xs, ys, xe, ye,
                                        input logic [7:0] col,
                                        output brl_pkg::pix_t px);
    int x0, y0, x1, y1, swap, e;
    px = '0;
    if (f == brl_pkg::FUNC_START) begin
      x0 = xs;
      y0 = ys;
      x1 = xe;
      y1 = ye;
      run_x  = (x0 < x1) ? x1 - x0 : x0 - x1;
      run_y  = (y0 < y1) ? y1 - y0 : y0 - y1;
      x_back = !(x0 < x1);
      y_back = !(y0 < y1);
      // Integer division truncates toward zero, which is what the engine wants.
      slope_err = ((run_x > run_y) ? run_x : -run_y) / 2;
      // Lines along an axis are always walked from low to high coordinate.
      if (run_x == 0 || run_y == 0) begin
        if (x1 < x0) begin
          swap = x0; x0 = x1; x1 = swap;
        end
        if (y1 < y0) begin
          swap = y0; y0 = y1; y1 = swap;
        end
        x_back = 1'b0;
        y_back = 1'b0;
      end
      pen_x     = x0;
      pen_y     = y0;
      goal_x    = x1;
      goal_y    = y1;
      pen_color = col;
      drawing   = 1'b1;
      return 1'b0;
    end
    if (!drawing) return 1'b0;
    px.x       = pen_x[15:0];
    px.y       = pen_y[15:0];
    px.color   = pen_color;
    px.visible = (pen_x >= 0) && (pen_y >= 0) && (pen_x < SCREEN_W) && (pen_y < SCREEN_H);
    px.last    = (pen_x == goal_x) && (pen_y == goal_y);
    if (px.last) begin
      drawing = 1'b0;
    end else begin
      e = slope_err;
      if (e > -run_x) begin
        slope_err -= run_y;
        pen_x += x_back ? -1 : 1;
      end
      if (e < run_y) begin
        slope_err += run_x;
        pen_y += y_back ? -1 : 1;
      end
    end
    return 1'b1;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one beat on the input and returns at the falling edge after it was
  // accepted. Valid is only lowered when a gap is actually inserted, so a
  // back-to-back beat keeps valid high without a glitch in the same step.
  task automatic send_beat(input brl_pkg::func_t f,
                           input logic signed [15:0] xs, ys, xe, ye,
                           input logic [7:0] col);
    int            gap;
    brl_pkg::pix_t px;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func     <= f;
    x_start  <= xs;
    y_start  <= ys;
    x_end    <= xe;
    y_end    <= ye;
    color    <= col;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    // Steps on an idle engine are ignored and do not count as work.
    if (f == brl_pkg::FUNC_START || drawing) beat_count++;
    if (rasterize_beat(f, xs, ys, xe, ye, col, px)) pending_pixels.push_back(px);
    @(negedge clk);
  endtask

  // A step beat; its coordinate and color fields carry random junk that the
  // block must ignore.
  task automatic tick_pixel();
    send_beat(brl_pkg::FUNC_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 8'($urandom));
  endtask

  task automatic send_line(input int x0, y0, x1, y1, input logic [7:0] col, input int steps);
    send_beat(brl_pkg::FUNC_START, 16'(x0), 16'(y0), 16'(x1), 16'(y1), col);
    repeat (steps) tick_pixel();
  endtask

  // Steps before any line was started must produce nothing at all.
  task automatic test_idle_steps();
    repeat (2) tick_pixel();
  endtask

  // A line whose two endpoints coincide gives exactly one pixel, marked last;
  // the following step finds the engine idle again.
  task automatic test_single_point();
    send_line(5, 5, 5, 5, 8'hff, 2);
  endtask

  // Vertical line given top-down reversed and a horizontal line given right to
  // left; both must come out in ascending order.
  task automatic test_axis_lines();
    send_line(10, 20, 10, 17, 8'h5a, 4);
    send_line(2, 100, -1, 100, 8'ha5, 4);
  endtask

  // Full-range diagonals: the spans only fit in widened arithmetic. The second
  // start arrives while the first line is still being drawn and abandons it.
  task automatic test_extremes();
    send_line(-32768, -32768, 32767, 32767, 8'h00, 2);
    send_line(32767, -32768, -32768, 32767, 8'hff, 2);
  endtask

  // A short line that enters the screen from the left, crossing the visible flag.
  task automatic test_screen_edge();
    send_line(-1, 1, 1, 0, 8'h3c, 3);
  endtask

  // The receiver holds off for a long stretch while steps keep coming; the
  // internal queue fills and the input must stall until the output drains.
  task automatic test_backpressure();
    steady = 1'b1;
    send_line(0, 0, 100, 37, 8'h77, 0);
    hold_off_pending = 1'b1;
    repeat (60) tick_pixel();
    steady = 1'b0;
  endtask

  // Mostly complete lines with random geometry, plus lines cut short by a new
  // start, extra steps after the last pixel, and stray steps as noise.
  task automatic test_random();
    int r, x0, y0, x1, y1, base_x, base_y, len, steps;
    while (beat_count < BEAT_TARGET) begin
      steady = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 3)) tick_pixel();
      end else begin
        if (r < 60) begin
          // Around the screen, so pixels fall on both sides of every border.
          x0 = -24 + int'($urandom_range(0, 367));
          y0 = -24 + int'($urandom_range(0, 287));
          x1 = x0 - 30 + int'($urandom_range(0, 60));
          y1 = y0 - 30 + int'($urandom_range(0, 60));
        end else if (r < 74) begin
          // Along an axis, or a single point when both spans come out zero.
          x0 = -8 + int'($urandom_range(0, 335));
          y0 = -8 + int'($urandom_range(0, 255));
          x1 = x0;
          y1 = y0;
          if ($urandom_range(0, 1)) x1 = x0 - 20 + int'($urandom_range(0, 40));
          else y1 = y0 - 20 + int'($urandom_range(0, 40));
        end else if (r < 88) begin
          // Close to the edges of the 16-bit coordinate range.
          base_x = $urandom_range(0, 1) ? -32768 : 32767 - 40;
          base_y = $urandom_range(0, 1) ? -32768 : 32767 - 40;
          x0 = base_x + int'($urandom_range(0, 40));
          x1 = base_x + int'($urandom_range(0, 40));
          y0 = base_y + int'($urandom_range(0, 40));
          y1 = base_y + int'($urandom_range(0, 40));
        end else begin
          // Anywhere at all; mostly too long to finish, so only a few pixels are drawn.
          x0 = $signed(16'($urandom));
          y0 = $signed(16'($urandom));
          x1 = $signed(16'($urandom));
          y1 = $signed(16'($urandom));
        end
        len = (x1 > x0 ? x1 - x0 : x0 - x1);
        if ((y1 > y0 ? y1 - y0 : y0 - y1) > len) len = (y1 > y0 ? y1 - y0 : y0 - y1);
        len = len + 1;
        r = $urandom_range(0, 99);
        if (len > 100) steps = $urandom_range(0, 8);
        else if (r < 70) steps = len;
        else if (r < 85) steps = len + int'($urandom_range(1, 3));
        else steps = $urandom_range(0, len - 1);
        send_line(x0, y0, x1, y1, 8'($urandom), steps);
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: ready drops for random stretches, or for one long hold-off when
  // a test asks for it. Exactly one assignment to out_ready per falling edge.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every pixel beat on the output is compared, field by field, with the
  // oldest prediction. Outputs are sampled at the rising edge.
  always @(posedge clk) begin
    brl_pkg::pix_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel beat: x=%0d y=%0d", pixel_x, pixel_y);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
          mismatch_count++;
        end
        if (pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
          mismatch_count++;
        end
        if (pixel_color !== want.color) begin
          $error("pixel_color: expected %0h, got %0h", want.color, pixel_color);
          mismatch_count++;
        end
        if (visible !== want.visible) begin
          $error("visible: expected %0b, got %0b", want.visible, visible);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a run where neither side moves a beat for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    func             = brl_pkg::FUNC_START;
    x_start          = '0;
    y_start          = '0;
    x_end            = '0;
    y_end            = '0;
    color            = '0;
    steady           = 1'b0;
    hold_off_pending = 1'b0;
    drawing          = 1'b0;
    beat_count       = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_steps();
    test_single_point();
    test_axis_lines();
    test_extremes();
    test_screen_edge();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;

    // Let the output drain with the receiver always ready, then keep watching
    // a little longer for any stray pixel.
    steady = 1'b1;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
